### sv/cdq_pkg.sv
// Shared types, constants and helper functions for the CD subchannel Q generator.
// No dependencies.
package cdq_pkg;

  localparam int MAX_TRACKS = 99;
  localparam int ADDR_W     = 19;
  localparam int NUM_W      = 7;
  localparam int CNT_W      = $clog2(MAX_TRACKS + 1);
  localparam int STEP_W     = $clog2(MAX_TRACKS);
  localparam int REM_W      = 7;
  localparam int QUO_W      = 13;
  localparam int DIV_W      = ADDR_W + 1;   // address plus lead-in can carry
  localparam int RCP_SHIFT  = 26;
  localparam int RCP_W      = 21;
  localparam int PROD_W     = DIV_W + RCP_W;

  localparam logic [ADDR_W-1:0] LEAD_IN     = ADDR_W'(150);
  localparam logic [REM_W-1:0]  FRAMES_PER_S = REM_W'(75);
  localparam logic [REM_W-1:0]  SECS_PER_M   = REM_W'(60);
  localparam logic [RCP_W-1:0]  RCP_75       = RCP_W'(894785);   // ceil(2^26 / 75)
  localparam logic [RCP_W-1:0]  RCP_60       = RCP_W'(1118482);  // ceil(2^26 / 60)
  localparam logic [7:0]        CTRL_AUDIO   = 8'h01;
  localparam logic [7:0]        CTRL_DATA    = 8'h41;
  localparam logic [7:0]        INDEX_ONE    = 8'h01;
  localparam logic [15:0]       CRC_POLY     = 16'h1021;
  localparam int                Q_BYTES      = 10;
  localparam int                BIDX_W       = $clog2(Q_BYTES);

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } cdq_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_LOOK,
    S_PREP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_CRC,
    S_OUT
  } cdq_state_t;

  typedef enum logic [1:0] {
    DV_REL_FRAMES,
    DV_REL_SECONDS,
    DV_ABS_FRAMES,
    DV_ABS_SECONDS
  } cdq_div_t;

  typedef struct packed {
    logic [NUM_W-1:0]  number;
    logic [ADDR_W-1:0] start;
    logic              audio;
  } cdq_entry_t;

  typedef struct packed {
    logic wr_en;
    logic shift;
  } cdq_cell_ctl_t;

  // Binary to BCD for values below 100; v/10 via reciprocal 205/2048.
  function automatic logic [7:0] to_bcd(input logic [NUM_W-1:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

  // One byte of CRC-16, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### sv/cdq_cell.sv
// One track table cell of the rotating ring: holds one entry.
// Depends on cdq_pkg.
module cdq_cell
  import cdq_pkg::*;
(
  input  logic          clk,
  input  cdq_cell_ctl_t ctl,
  input  cdq_entry_t    wr_entry,
  input  cdq_entry_t    nbr_entry,  // from the next cell along the ring
  output cdq_entry_t    entry
);

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      entry <= wr_entry;
    end else if (ctl.shift) begin
      entry <= nbr_entry;
    end
  end

endmodule

### sv/cdq_divider.sv
// Division by 75 or by 60 through reciprocal multiplication, pipelined:
// operands, product, quotient, remainder. done rises as the remainder is registered.
// Depends on cdq_pkg.
module cdq_divider
  import cdq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic             by_sixty,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [REM_W-1:0] remainder
);

  logic [2:0]        stage;
  logic [DIV_W-1:0]  num;
  logic [REM_W-1:0]  den;
  logic [RCP_W-1:0]  rcp;
  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0]  back;

  // quotient times divisor, for the remainder
  assign back = quotient * DIV_W'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[1:0], start};
      done  <= stage[2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= by_sixty ? SECS_PER_M : FRAMES_PER_S;
      rcp <= by_sixty ? RCP_60 : RCP_75;
    end
    if (stage[0]) prod      <= PROD_W'(num) * PROD_W'(rcp);
    if (stage[1]) quotient  <= DIV_W'(prod[PROD_W-1:RCP_SHIFT]);
    if (stage[2]) remainder <= REM_W'(num - back);
  end

endmodule

### sv/cd_subchannel_q_generator.sv
// Top level: CD subchannel Q position frame generator (track ring, divider, CRC).
// Depends on cdq_pkg, cdq_cell, cdq_divider.
//
//  channel | direction | tuser         | tdata
//  s_*     | in        | kind          | sector_address, entry_number, entry_start, entry_audio
//  m_*     | out       | -             | Q frame bytes 0-8, frame_crc, q_valid
//
// Clear and append are handled in the idle state, which stays ready. A query
// runs from its accepting edge to m_tvalid through two full turns of the
// 99-cell track ring (find track, then look up its start), one step to form
// the sector counts, four divisions (a start state, then a wait for done),
// ten CRC byte steps and one output load; s_tready returns as m_tvalid rises.
// One item is in work at a time; s_tready is high only while idle.
// The result sits in an output register; a stalled m_tready holds the block
// in its final state until that register is free.
// rst is synchronous and empties the table (entry count to zero).
module cd_subchannel_q_generator
  import cdq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] kind
  // [18:0] sector_address, [25:19] entry_number, [44:26] entry_start,
  // [45] entry_audio, [47:46] zero
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] control_adr, [15:8] track_bcd, [23:16] index_bcd,
  // [31:24] rel_minutes_bcd, [39:32] rel_seconds_bcd, [47:40] rel_frames_bcd,
  // [55:48] abs_minutes_bcd, [63:56] abs_seconds_bcd, [71:64] abs_frames_bcd,
  // [87:72] frame_crc, [88] q_valid, [95:89] zero
  output logic [95:0] m_tdata
);

  cdq_state_t state, state_next;
  cdq_kind_t  kind;
  logic       in_fire;

  // Ring of track cells: cell 0 is the head examined during a walk.
  cdq_entry_t    ring [MAX_TRACKS];
  cdq_cell_ctl_t cell_ctl [MAX_TRACKS];
  cdq_entry_t    wr_entry;
  logic          rotate;
  logic          append_ok;

  logic [CNT_W-1:0]  count;
  logic [STEP_W-1:0] step;
  logic              step_last;
  logic              in_table;

  // Query working registers
  logic [ADDR_W-1:0] addr;
  logic [NUM_W-1:0]  track;
  logic              stopped;
  logic              found;
  logic [ADDR_W-1:0] tstart;
  logic              audio;
  logic [ADDR_W-1:0] rel;
  logic [DIV_W-1:0]  absv;
  logic [QUO_W-1:0]  quo_mid;
  logic [REM_W-1:0]  rel_min, rel_sec, rel_fr;
  logic [REM_W-1:0]  abs_min, abs_sec, abs_fr;
  cdq_div_t          div_sel;

  // Divider
  logic              div_start;
  logic              div_done;
  logic [DIV_W-1:0]  div_dividend;
  logic              div_by_sixty;
  logic [DIV_W-1:0]  div_quo;
  logic [REM_W-1:0]  div_rem;

  // CRC
  logic [BIDX_W-1:0] bidx;
  logic [15:0]       crc;
  logic [7:0]        qb [Q_BYTES];
  logic [7:0]        cur_byte;
  logic              out_free;

  assign kind      = cdq_kind_t'(s_tuser);
  assign in_fire   = s_tvalid && s_tready;
  assign append_ok = in_fire && (kind == KIND_APPEND) && (count < CNT_W'(MAX_TRACKS));
  assign step_last = step == STEP_W'(MAX_TRACKS - 1);
  assign in_table  = CNT_W'(step) < count;
  assign out_free  = !m_tvalid || m_tready;

  assign wr_entry.number = s_tdata[25:19];
  assign wr_entry.start  = s_tdata[44:26];
  assign wr_entry.audio  = s_tdata[45];

  for (genvar i = 0; i < MAX_TRACKS; i++) begin : g_cell
    assign cell_ctl[i].wr_en = append_ok && (count == CNT_W'(i));
    assign cell_ctl[i].shift = rotate;
    cdq_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[i]),
      .wr_entry (wr_entry),
      .nbr_entry(ring[(i + 1) % MAX_TRACKS]),
      .entry    (ring[i])
    );
  end

  cdq_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .by_sixty (div_by_sixty),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && kind == KIND_QUERY) state_next = S_FIND;
      end
      S_FIND: begin
        if (step_last) state_next = S_LOOK;
      end
      S_LOOK: begin
        if (step_last) state_next = S_PREP;
      end
      S_PREP:   state_next = S_DIV_GO;
      S_DIV_GO: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) state_next = (div_sel == DV_ABS_SECONDS) ? S_CRC : S_DIV_GO;
      end
      S_CRC: begin
        if (bidx == BIDX_W'(Q_BYTES - 1)) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    s_tready  = 1'b0;
    rotate    = 1'b0;
    div_start = 1'b0;
    unique case (state)
      S_IDLE:   s_tready  = 1'b1;
      S_FIND,
      S_LOOK:   rotate    = 1'b1;
      S_DIV_GO: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (in_fire && kind == KIND_CLEAR) begin
        count <= '0;
      end else if (append_ok) begin
        count <= count + 1'b1;
      end
    end
  end

  // Divider operand selection
  always_comb begin
    unique case (div_sel)
      DV_REL_FRAMES:  begin div_dividend = DIV_W'(rel);     div_by_sixty = 1'b0; end
      DV_REL_SECONDS: begin div_dividend = DIV_W'(quo_mid); div_by_sixty = 1'b1; end
      DV_ABS_FRAMES:  begin div_dividend = absv;            div_by_sixty = 1'b0; end
      DV_ABS_SECONDS: begin div_dividend = DIV_W'(quo_mid); div_by_sixty = 1'b1; end
      default:        begin div_dividend = DIV_W'(rel);     div_by_sixty = 1'b0; end
    endcase
  end

  // Frame bytes 0..9
  always_comb begin
    qb[0] = audio ? CTRL_AUDIO : CTRL_DATA;
    qb[1] = to_bcd(track);
    qb[2] = INDEX_ONE;
    qb[3] = to_bcd(rel_min);
    qb[4] = to_bcd(rel_sec);
    qb[5] = to_bcd(rel_fr);
    qb[6] = to_bcd(abs_min);
    qb[7] = to_bcd(abs_sec);
    qb[8] = to_bcd(abs_fr);
    qb[9] = 8'h00;
    cur_byte = (bidx < BIDX_W'(Q_BYTES)) ? qb[bidx] : 8'h00;
  end

  // Walk, division and CRC datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        addr    <= s_tdata[ADDR_W-1:0];
        track   <= NUM_W'(1);
        stopped <= 1'b0;
        found   <= 1'b0;
        tstart  <= '0;
        audio   <= 1'b0;
        step    <= '0;
      end
      S_FIND: begin
        // current track: last entry passed before a start beyond the address
        if (in_table && !stopped) begin
          if (ring[0].start > addr) stopped <= 1'b1;
          else                      track   <= ring[0].number;
        end
        step <= step_last ? '0 : step + 1'b1;
      end
      S_LOOK: begin
        // first entry carrying the current track number
        if (in_table && !found && ring[0].number == track) begin
          found  <= 1'b1;
          tstart <= ring[0].start;
          audio  <= ring[0].audio;
        end
        step <= step_last ? '0 : step + 1'b1;
      end
      S_PREP: begin
        rel     <= (addr >= tstart) ? addr - tstart : '0;
        absv    <= DIV_W'(addr) + DIV_W'(LEAD_IN);
        div_sel <= DV_REL_FRAMES;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          unique case (div_sel)
            DV_REL_FRAMES: begin
              rel_fr  <= div_rem;
              quo_mid <= div_quo[QUO_W-1:0];
              div_sel <= DV_REL_SECONDS;
            end
            DV_REL_SECONDS: begin
              rel_sec <= div_rem;
              rel_min <= div_quo[REM_W-1:0];
              div_sel <= DV_ABS_FRAMES;
            end
            DV_ABS_FRAMES: begin
              abs_fr  <= div_rem;
              quo_mid <= div_quo[QUO_W-1:0];
              div_sel <= DV_ABS_SECONDS;
            end
            DV_ABS_SECONDS: begin
              abs_sec <= div_rem;
              abs_min <= div_quo[REM_W-1:0];
            end
            default: ;
          endcase
          crc  <= '0;
          bidx <= '0;
        end
      end
      S_CRC: begin
        crc  <= crc_byte(crc, cur_byte);
        bidx <= bidx + 1'b1;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata <= {7'b0, 1'b1, ~crc, qb[8], qb[7], qb[6], qb[5], qb[4], qb[3],
                  qb[2], qb[1], qb[0]};
    end
  end

endmodule

### bench/tb_cd_subchannel_q_generator.sv
// Testbench for cd_subchannel_q_generator: table loads, position queries and
// Q frame checks against an in-bench predictor, with random flow control.
// Depends on cdq_pkg and the RTL under sv/.
`timescale 1ns / 100ps

module tb_cd_subchannel_q_generator;
  import cdq_pkg::*;

  localparam int unsigned SECTORS_PER_MIN = 4500;
  localparam int unsigned SECTORS_PER_SEC = 75;
  localparam int unsigned ADDR_TOP        = 449849;   // last sector of a full disc
  localparam int unsigned ADDR_ALL_ONES   = 524287;   // widest value the field carries
  localparam int unsigned ITEM_TARGET     = 1200;
  localparam int unsigned LONG_HOLD       = 2500;     // receiver hold-off, in cycles
  localparam int unsigned DRAIN_CYCLES    = 400;      // longer than one query takes to finish
  localparam int unsigned CYCLE_LIMIT     = 5000000;
  localparam int unsigned MAX_SHOWN       = 40;

  typedef enum logic [1:0] {
    SINK_OPEN,       // always ready
    SINK_COIN,       // ready half the time
    SINK_TIGHT,      // ready one cycle in ten
    SINK_PERIODIC    // fixed repeating low-then-high pattern
  } sink_mode_t;

  // One Q frame as it leaves the block: bytes 0-8, CRC, flag and pad bits.
  typedef struct {
    logic [7:0]  body [9];
    logic [15:0] crc;
    logic        q_valid;
    logic [6:0]  pad;
  } q_frame_t;

  // Track table mirror plus the queue of Q frames still owed by the block.
  class q_frame_checker;
    cdq_entry_t  tracks [MAX_TRACKS];
    int unsigned loaded;
    q_frame_t    owed_frames [$];
    int unsigned mismatches;
    int unsigned frames_checked;
    string       byte_name [9] = '{"control_adr", "track_bcd", "index_bcd",
                                   "rel_minutes_bcd", "rel_seconds_bcd", "rel_frames_bcd",
                                   "abs_minutes_bcd", "abs_seconds_bcd", "abs_frames_bcd"};

    function new();
      loaded = 0;
      mismatches = 0;
      frames_checked = 0;
      foreach (tracks[i]) tracks[i] = '0;
    endfunction

    task report_mismatch(string what);
      if (mismatches < MAX_SHOWN) $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
    endtask

    function automatic logic [7:0] bcd8(int unsigned v);
      return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    // CRC-16/0x1021, MSB first, one bit at a time.
    function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic fb;
      for (int k = 7; k >= 0; k--) begin
        fb  = crc[15] ^ b[k];
        crc = crc << 1;
        if (fb) crc = crc ^ 16'h1021;
      end
      return crc;
    endfunction

    function automatic q_frame_t build_frame(logic [ADDR_W-1:0] addr);
      q_frame_t          f;
      logic [NUM_W-1:0]  track;
      logic [ADDR_W-1:0] tstart;
      logic              audio;
      bit                found;
      int unsigned       rel, absv;
      logic [15:0]       crc;
      // walk in load order; stop at the first start past the address
      track = NUM_W'(1);
      for (int unsigned i = 0; i < loaded; i++) begin
        if (tracks[i].start > addr) break;
        track = tracks[i].number;
      end
      // first entry with that number wins; no entry means start 0, data
      tstart = '0;
      audio  = 1'b0;
      found  = 1'b0;
      for (int unsigned i = 0; i < loaded && !found; i++) begin
        if (tracks[i].number == track) begin
          tstart = tracks[i].start;
          audio  = tracks[i].audio;
          found  = 1'b1;
        end
      end
      rel  = (addr >= tstart) ? 32'(addr) - 32'(tstart) : 0;
      absv = 32'(addr) + 32'(LEAD_IN);
      f.body[0] = audio ? CTRL_AUDIO : CTRL_DATA;
      f.body[1] = bcd8(32'(track));
      f.body[2] = INDEX_ONE;
      f.body[3] = bcd8(rel / SECTORS_PER_MIN);
      f.body[4] = bcd8((rel / SECTORS_PER_SEC) % 60);
      f.body[5] = bcd8(rel % SECTORS_PER_SEC);
      f.body[6] = bcd8(absv / SECTORS_PER_MIN);
      f.body[7] = bcd8((absv / SECTORS_PER_SEC) % 60);
      f.body[8] = bcd8(absv % SECTORS_PER_SEC);
      crc = 16'h0000;
      for (int i = 0; i < 9; i++) crc = crc_step(crc, f.body[i]);
      crc = crc_step(crc, 8'h00);   // byte 9 is always zero
      f.crc     = ~crc;
      f.q_valid = 1'b1;
      f.pad     = '0;
      return f;
    endfunction

    function void note_item(cdq_kind_t kind, logic [47:0] d);
      cdq_entry_t e;
      e.number = d[25:19];
      e.start  = d[44:26];
      e.audio  = d[45];
      case (kind)
        KIND_CLEAR: begin
          foreach (tracks[i]) tracks[i] = '0;
          loaded = 0;
        end
        KIND_APPEND: begin
          if (loaded < MAX_TRACKS) begin
            tracks[loaded] = e;
            loaded++;
          end
        end
        KIND_QUERY: owed_frames = {owed_frames, build_frame(d[18:0])};
        default: ;
      endcase
    endfunction

    task check_frame(logic [95:0] d);
      q_frame_t want;
      q_frame_t got;
      for (int i = 0; i < 9; i++) got.body[i] = d[8*i +: 8];
      got.crc     = d[87:72];
      got.q_valid = d[88];
      got.pad     = d[95:89];
      if (owed_frames.size() == 0) begin
        report_mismatch($sformatf("frame with no query waiting: %h", d));
      end else begin
        want = owed_frames.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.body[i] !== want.body[i])
            report_mismatch($sformatf("frame %0d %s: got %h, want %h",
                                      frames_checked, byte_name[i], got.body[i], want.body[i]));
        if (got.crc !== want.crc)
          report_mismatch($sformatf("frame %0d frame_crc: got %h, want %h",
                                    frames_checked, got.crc, want.crc));
        if (got.q_valid !== want.q_valid)
          report_mismatch($sformatf("frame %0d q_valid: got %b", frames_checked, got.q_valid));
        if (got.pad !== want.pad)
          report_mismatch($sformatf("frame %0d pad bits: got %h", frames_checked, got.pad));
      end
      frames_checked++;
    endtask

    function int unsigned pending();
      return owed_frames.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = KIND_NONE;    // [1:0] kind
  // [18:0] sector_address, [25:19] entry_number, [44:26] entry_start,
  // [45] entry_audio, [47:46] zero
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [7:0] control_adr ... [71:64] abs_frames_bcd, [87:72] frame_crc, [88] q_valid
  logic [95:0] m_tdata;

  q_frame_checker frames = new();
  int unsigned    items_sent = 0;     // transactions the block acts on (kind 3 excluded)
  int unsigned    burst_left = 0;
  int unsigned    cycle_count = 0;

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  cd_subchannel_q_generator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  function automatic logic [47:0] pack_item(int unsigned addr, int unsigned num,
                                            int unsigned start, bit audio);
    return {2'b00, audio, 19'(start), 7'(num), 19'(addr)};
  endfunction

  // Offer one transaction, hold it until accepted, then maybe open a gap.
  // valid is only lowered when a real gap follows, so it never drops and
  // rises within one time step.
  task automatic send_item(cdq_kind_t kind, logic [47:0] d);
    int unsigned gap;
    s_tuser  <= kind;
    s_tdata  <= d;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    frames.note_item(kind, d);
    if (kind != KIND_NONE) items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: gap = 0;
        17, 18, 19:             gap = $urandom_range(7, 320);
        default:                gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 15);
    end
  endtask

  task automatic query_at(int unsigned addr);
    send_item(KIND_QUERY, pack_item(addr, $urandom_range(0, 127), $urandom, $urandom_range(0, 1)));
  endtask

  task automatic append_track(int unsigned num, int unsigned start, bit audio);
    send_item(KIND_APPEND, pack_item($urandom, num, start, audio));
  endtask

  task automatic clear_table();
    send_item(KIND_CLEAR, pack_item($urandom, $urandom, $urandom, $urandom_range(0, 1)));
  endtask

  function automatic int unsigned pick_addr();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return ADDR_TOP;
      2:       return $urandom_range(ADDR_TOP + 1, ADDR_ALL_ONES);
      default: return $urandom_range(0, ADDR_TOP);
    endcase
  endfunction

  // A well-formed disc: clear, a handful of tracks with starts that never fall, then
  // queries around the track boundaries.
  task automatic run_disc_session();
    int unsigned starts [$];
    int unsigned ntracks, base_num, start_at, addr, j;
    clear_table();
    ntracks  = $urandom_range(1, 12);
    base_num = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 88);
    start_at = $urandom_range(0, 20000);
    for (int unsigned i = 0; i < ntracks; i++) begin
      starts = {starts, start_at};
      append_track((base_num + i) % 128, start_at, $urandom_range(0, 1));
      start_at = start_at + $urandom_range(1, 60000);
      if (start_at > ADDR_TOP) start_at = ADDR_TOP;
    end
    repeat ($urandom_range(1, 15)) begin
      j = $urandom_range(0, ntracks - 1);
      case ($urandom_range(0, 4))
        0:       addr = (starts[j] > 0) ? starts[j] - 1 : 0;
        1:       addr = starts[j];
        2:       addr = starts[j] + $urandom_range(0, 5000);
        default: addr = pick_addr();
      endcase
      if (addr > ADDR_ALL_ONES) addr = ADDR_ALL_ONES;
      query_at(addr);
    end
  endtask

  // Fill the table past its size so the surplus appends are dropped.
  task automatic run_full_table();
    int unsigned start_at;
    clear_table();
    start_at = $urandom_range(0, 1000);
    for (int unsigned i = 0; i < MAX_TRACKS + $urandom_range(1, 4); i++) begin
      append_track((i % 99) + 1, start_at, $urandom_range(0, 1));
      start_at = start_at + $urandom_range(0, 4500);
      if (start_at > ADDR_TOP) start_at = ADDR_TOP;
    end
    repeat ($urandom_range(3, 8)) query_at(pick_addr());
  endtask

  // Anything the fields can carry, in any order, kind 3 included.
  task automatic run_noise();
    repeat ($urandom_range(4, 20))
      send_item(cdq_kind_t'($urandom_range(0, 3)),
                pack_item($urandom_range(0, ADDR_ALL_ONES), $urandom_range(0, 127),
                          $urandom_range(0, ADDR_ALL_ONES), $urandom_range(0, 1)));
  endtask

  // Result side: checks every frame and stalls in changing patterns, with
  // one long hold-off so the block backs up onto its input.
  initial begin : frame_sink
    sink_mode_t  mode;
    int unsigned mode_left;
    int unsigned phase;
    bit          held;
    mode      = SINK_OPEN;
    mode_left = 0;
    phase     = 0;
    held      = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) frames.check_frame(m_tdata);
      if (!held && frames.frames_checked >= 40) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 600);
      end
      mode_left--;
      phase++;
      case (mode)
        SINK_OPEN:  m_tready <= 1'b1;
        SINK_COIN:  m_tready <= 1'($urandom_range(0, 1));
        SINK_TIGHT: m_tready <= ($urandom_range(0, 9) == 0);
        default:    m_tready <= ((phase % 7) >= 3);
      endcase
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_cd_subchannel_q_generator failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    query_at(0);                    // empty table: track 1, data, abs 00:02:00
    query_at(ADDR_ALL_ONES);        // minutes above 99
    send_item(KIND_NONE, '1);       // unused kind, no frame
    append_track(1, 0, 1'b1);
    append_track(2, 1000, 1'b0);
    append_track(3, 300000, 1'b1);
    query_at(999);                  // one before a track start
    query_at(1000);                 // exactly on a start
    query_at(ADDR_TOP);
    append_track(5, 500, 1'b1);     // start out of order: the walk stops early
    query_at(600);
    append_track(2, 200, 1'b1);     // duplicate number: first entry is used
    query_at(400000);
    append_track(127, 450000, 1'b0); // track number above 99
    query_at(460000);
    clear_table();
    append_track(1, 5000, 1'b1);    // address before the track's start: rel is zero
    query_at(100);
    clear_table();
    append_track(2, 5000, 1'b0);    // track 1 not in table
    query_at(100);
    clear_table();
    append_track(0, 0, 1'b1);       // track number zero
    query_at(77);

    // --- random ---
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) run_disc_session();
      else if (pick < 80) run_full_table();
      else run_noise();
    end
    s_tvalid <= 1'b0;

    while (frames.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frames.mismatches == 0)
      $display("tb_cd_subchannel_q_generator passed");
    else
      $display("tb_cd_subchannel_q_generator failed");
    $finish;
  end

endmodule
